/* hw/rtl/apx_pkg.sv */
`timescale 1ns / 1ps
package apx_pkg;

   localparam int COLOR_W         = 16;
   localparam int CNT_W           = 13;
   localparam int SPREAD_W        = 32;
   localparam int THR_W           = 31;
   localparam int HALTON_W        = 16;
   localparam int NUM_CH          = 3;
   localparam int MAX_SAMPLES     = 4096;
   localparam int COLOR_FRAC_BITS = 12;
   localparam int SQ_SHIFT        = 2 * COLOR_FRAC_BITS - 16;
   localparam int SQ_W            = 2 * COLOR_W;
   localparam int TERM_W          = SQ_W - SQ_SHIFT + CNT_W;
   localparam int SUM_W           = TERM_W + 3;
   localparam int ADDR_W          = 5;
   localparam int CSR_W           = 32;
   localparam int STEP_W          = 5;
   localparam int DEN_W           = 15;
   localparam int DIGIT_W         = 4;

   // radical inverse bases and reciprocals for the digit split
   localparam int BASE_X   = 11;
   localparam int RECIP_X  = 5958;
   localparam int SHIFT_X  = 16;
   localparam int BASE_Y   = 13;
   localparam int RECIP_Y  = 10083;
   localparam int SHIFT_Y  = 17;
   localparam int HDIG_STEPS = 4;

   // bit-serial schedule inside the run phase
   localparam int COLOR_STEPS  = COLOR_W;
   localparam int SPREAD_STEPS = SPREAD_W;

   typedef enum logic [2:0] {
      REG_THRESH_RED   = 3'd0,
      REG_THRESH_GREEN = 3'd1,
      REG_THRESH_BLUE  = 3'd2,
      REG_MIN_SAMPLES  = 3'd3,
      REG_MAX_SAMPLES  = 3'd4
   } csr_index_type;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_RUN  = 6'b000010,
      ST_SQR  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_UPD  = 6'b010000,
      ST_FIN  = 6'b100000
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]   quo;
      logic [DIGIT_W-1:0] rem;
   } digit_type;

   // split off the lowest digit by a reciprocal multiply
   function automatic digit_type split_digit(input logic [CNT_W-1:0] m, input int base,
                                             input int recip, input int shift);
      logic [31:0] prod;
      digit_type   res;
      prod    = 32'(m) * 32'(recip);
      res.quo = CNT_W'(prod >> shift);
      res.rem = DIGIT_W'(32'(m) - 32'(res.quo) * 32'(base));
      return res;
   endfunction

endpackage

/* hw/rtl/apx_if.sv */
`timescale 1ns / 1ps
interface apx_req_if;
   logic                        valid;
   logic                        ready;
   logic                        req_type;
   logic [apx_pkg::COLOR_W-1:0] color_red;
   logic [apx_pkg::COLOR_W-1:0] color_green;
   logic [apx_pkg::COLOR_W-1:0] color_blue;

   modport source (output valid, req_type, color_red, color_green, color_blue, input ready);
   modport sink   (input valid, req_type, color_red, color_green, color_blue, output ready);
endinterface

interface apx_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [apx_pkg::CNT_W-1:0]    sample_index;
   logic [apx_pkg::HALTON_W-1:0] offset_x;
   logic [apx_pkg::HALTON_W-1:0] offset_y;
   logic                         more_samples;
   logic [apx_pkg::COLOR_W-1:0]  mean_red;
   logic [apx_pkg::COLOR_W-1:0]  mean_green;
   logic [apx_pkg::COLOR_W-1:0]  mean_blue;

   modport source (output valid, sample_index, offset_x, offset_y, more_samples,
                   mean_red, mean_green, mean_blue, input ready);
   modport sink   (input valid, sample_index, offset_x, offset_y, more_samples,
                   mean_red, mean_green, mean_blue, output ready);
endinterface

/* hw/rtl/adaptive_pixel_sampler.sv */
`timescale 1ns / 1ps
// an accepted word passes the run, square, multiply, update and finish states in turn,
// then the result is registered; the run is set by the 32-step bit-serial spread divider
// the color divides, radical-inverse digits and halton fraction run in its shadow
// a new word is taken only in idle, even while the last result waits in the output register
// reset (synchronous, active high) clears count, means, spreads and loads register defaults
module adaptive_pixel_sampler (
   input  logic                        clock,
   input  logic                        reset,
   apx_req_if.sink                     req_bus,
   apx_rsp_if.source                   rsp_bus,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [apx_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [apx_pkg::CSR_W-1:0]   csr_pwdata,
   output logic [apx_pkg::CSR_W-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import apx_pkg::*;

   // configuration
   logic [THR_W-1:0] thr_ff [NUM_CH];
   logic [CNT_W-1:0] min_ff, max_ff;

   // pixel state
   logic [CNT_W-1:0]           count_ff;
   logic [COLOR_W-1:0]         mean_ff   [NUM_CH];
   logic signed [SPREAD_W-1:0] spread_ff [NUM_CH];

   // sequencer
   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              upd_ff;

   // bit-serial divider lanes
   logic [COLOR_W-1:0]  cdiv_ff [NUM_CH];
   logic [CNT_W-1:0]    crem_ff [NUM_CH];
   logic                cneg_ff [NUM_CH];
   logic [SPREAD_W-1:0] sdiv_ff [NUM_CH];
   logic [CNT_W-1:0]    srem_ff [NUM_CH];
   logic                sneg_ff [NUM_CH];
   logic signed [COLOR_W:0] dc_ff [NUM_CH];
   logic [SQ_W-1:0]     sq_ff   [NUM_CH];
   logic [TERM_W-1:0]   term_ff [NUM_CH];

   // halton lanes: 0 is x (base 11), 1 is y (base 13)
   logic [CNT_W-1:0]    hm_ff   [2];
   logic [DEN_W-1:0]    hrev_ff [2];
   logic [DEN_W-1:0]    hden_ff [2];
   logic [HALTON_W-1:0] hq_ff   [2];

   // output register
   logic                rsp_valid_ff;
   logic [CNT_W-1:0]    rsp_index_ff;
   logic [HALTON_W-1:0] rsp_x_ff, rsp_y_ff;
   logic                rsp_more_ff;
   logic [COLOR_W-1:0]  rsp_mean_ff [NUM_CH];

   logic             req_fire, cfg_write, out_free;
   logic [CNT_W-1:0] count_inc;
   logic [2:0]       cfg_index;
   logic [COLOR_W-1:0] req_color [NUM_CH];
   digit_type        dig_x, dig_y;

   assign req_fire  = req_bus.valid && req_bus.ready;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;
   assign cfg_index = csr_paddr[4:2];
   assign count_inc = count_ff + CNT_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign req_color[0] = req_bus.color_red;
   assign req_color[1] = req_bus.color_green;
   assign req_color[2] = req_bus.color_blue;
   assign dig_x = split_digit(hm_ff[0], BASE_X, RECIP_X, SHIFT_X);
   assign dig_y = split_digit(hm_ff[1], BASE_Y, RECIP_Y, SHIFT_Y);

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_pready    = 1'b1;

   // register read
   always_comb begin
      csr_prdata = '0;
      unique case (cfg_index)
         REG_THRESH_RED:   csr_prdata = CSR_W'(thr_ff[0]);
         REG_THRESH_GREEN: csr_prdata = CSR_W'(thr_ff[1]);
         REG_THRESH_BLUE:  csr_prdata = CSR_W'(thr_ff[2]);
         REG_MIN_SAMPLES:  csr_prdata = CSR_W'(min_ff);
         REG_MAX_SAMPLES:  csr_prdata = CSR_W'(max_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // register write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CH; c++) thr_ff[c] <= THR_W'(65536);
         min_ff <= CNT_W'(4);
         max_ff <= CNT_W'(64);
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_THRESH_RED:   thr_ff[0] <= csr_pwdata[THR_W-1:0];
            REG_THRESH_GREEN: thr_ff[1] <= csr_pwdata[THR_W-1:0];
            REG_THRESH_BLUE:  thr_ff[2] <= csr_pwdata[THR_W-1:0];
            REG_MIN_SAMPLES:  min_ff    <= csr_pwdata[CNT_W-1:0];
            REG_MAX_SAMPLES:  max_ff    <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer and pixel state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         upd_ff   <= 1'b0;
         count_ff <= '0;
         for (int c = 0; c < NUM_CH; c++) begin
            mean_ff[c]   <= '0;
            spread_ff[c] <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_RUN;
                  step_ff  <= '0;
                  upd_ff   <= req_bus.req_type && (count_ff < CNT_W'(MAX_SAMPLES));
                  if (!req_bus.req_type) begin
                     count_ff <= '0;
                     for (int c = 0; c < NUM_CH; c++) begin
                        mean_ff[c]   <= '0;
                        spread_ff[c] <= '0;
                     end
                  end
               end
            end
            ST_RUN: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(SPREAD_STEPS - 1)) state_ff <= ST_SQR;
            end
            ST_SQR: state_ff <= ST_MUL;
            ST_MUL: state_ff <= ST_UPD;
            ST_UPD: begin
               state_ff <= ST_FIN;
               if (upd_ff) begin
                  count_ff <= count_inc;
                  for (int c = 0; c < NUM_CH; c++) begin
                     logic signed [SUM_W-1:0] sum;
                     logic signed [SUM_W-1:0] quo;
                     mean_ff[c] <= mean_ff[c] + dc_ff[c][COLOR_W-1:0];
                     quo = sneg_ff[c] ? -SUM_W'(sdiv_ff[c]) : SUM_W'(sdiv_ff[c]);
                     sum = SUM_W'(spread_ff[c]) + SUM_W'(term_ff[c]) - quo;
                     if (count_ff != '0) begin
                        priority if (sum > SUM_W'(32'sh7fffffff)) begin
                           spread_ff[c] <= 32'sh7fffffff;
                        end else if (sum < -SUM_W'(33'sh080000000)) begin
                           spread_ff[c] <= 32'sh80000000;
                        end else begin
                           spread_ff[c] <= sum[SPREAD_W-1:0];
                        end
                     end
                  end
               end
            end
            ST_FIN: if (out_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // divider lanes, squares and halton datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         for (int c = 0; c < NUM_CH; c++) begin
            logic signed [COLOR_W:0] d;
            d = $signed({1'b0, req_color[c]}) - $signed({1'b0, mean_ff[c]});
            cneg_ff[c] <= d[COLOR_W];
            cdiv_ff[c] <= d[COLOR_W] ? COLOR_W'(-d) : d[COLOR_W-1:0];
            crem_ff[c] <= '0;
            sneg_ff[c] <= spread_ff[c][SPREAD_W-1];
            sdiv_ff[c] <= spread_ff[c][SPREAD_W-1] ? SPREAD_W'(-spread_ff[c])
                                                    : SPREAD_W'(spread_ff[c]);
            srem_ff[c] <= '0;
         end
         for (int h = 0; h < 2; h++) begin
            priority if (!req_bus.req_type) begin
               hm_ff[h] <= '0;
            end else if (count_ff < CNT_W'(MAX_SAMPLES)) begin
               hm_ff[h] <= count_inc;
            end else begin
               hm_ff[h] <= count_ff;
            end
            hrev_ff[h] <= '0;
            hden_ff[h] <= DEN_W'(1);
            hq_ff[h]   <= '0;
         end
      end else if (state_ff == ST_RUN) begin
         // one quotient bit per lane per cycle
         for (int c = 0; c < NUM_CH; c++) begin
            logic [CNT_W:0] ct, st;
            if (step_ff < STEP_W'(COLOR_STEPS)) begin
               ct = {crem_ff[c], cdiv_ff[c][COLOR_W-1]};
               if (ct >= {1'b0, count_inc}) begin
                  crem_ff[c] <= CNT_W'(ct - {1'b0, count_inc});
                  cdiv_ff[c] <= {cdiv_ff[c][COLOR_W-2:0], 1'b1};
               end else begin
                  crem_ff[c] <= ct[CNT_W-1:0];
                  cdiv_ff[c] <= {cdiv_ff[c][COLOR_W-2:0], 1'b0};
               end
            end
            st = {srem_ff[c], sdiv_ff[c][SPREAD_W-1]};
            if (st >= {1'b0, count_ff}) begin
               srem_ff[c] <= CNT_W'(st - {1'b0, count_ff});
               sdiv_ff[c] <= {sdiv_ff[c][SPREAD_W-2:0], 1'b1};
            end else begin
               srem_ff[c] <= st[CNT_W-1:0];
               sdiv_ff[c] <= {sdiv_ff[c][SPREAD_W-2:0], 1'b0};
            end
         end
         // halton: digit reversal first, then fraction bits rev * 2^16 / den
         if (step_ff < STEP_W'(HDIG_STEPS)) begin
            if (hm_ff[0] != '0) begin
               hm_ff[0]   <= dig_x.quo;
               hrev_ff[0] <= DEN_W'(32'(hrev_ff[0]) * 32'(BASE_X) + 32'(dig_x.rem));
               hden_ff[0] <= DEN_W'(32'(hden_ff[0]) * 32'(BASE_X));
            end
            if (hm_ff[1] != '0) begin
               hm_ff[1]   <= dig_y.quo;
               hrev_ff[1] <= DEN_W'(32'(hrev_ff[1]) * 32'(BASE_Y) + 32'(dig_y.rem));
               hden_ff[1] <= DEN_W'(32'(hden_ff[1]) * 32'(BASE_Y));
            end
         end else if (step_ff >= STEP_W'(SPREAD_STEPS - HALTON_W)) begin
            for (int h = 0; h < 2; h++) begin
               logic [DEN_W:0] ht;
               ht = {hrev_ff[h], 1'b0};
               if (ht >= {1'b0, hden_ff[h]}) begin
                  hrev_ff[h] <= DEN_W'(ht - {1'b0, hden_ff[h]});
                  hq_ff[h]   <= {hq_ff[h][HALTON_W-2:0], 1'b1};
               end else begin
                  hrev_ff[h] <= ht[DEN_W-1:0];
                  hq_ff[h]   <= {hq_ff[h][HALTON_W-2:0], 1'b0};
               end
            end
         end
      end else if (state_ff == ST_SQR) begin
         for (int c = 0; c < NUM_CH; c++) begin
            dc_ff[c] <= cneg_ff[c] ? -$signed({1'b0, cdiv_ff[c]}) : $signed({1'b0, cdiv_ff[c]});
            sq_ff[c] <= SQ_W'(cdiv_ff[c]) * SQ_W'(cdiv_ff[c]);
         end
      end else if (state_ff == ST_MUL) begin
         for (int c = 0; c < NUM_CH; c++) begin
            term_ff[c] <= TERM_W'(sq_ff[c][SQ_W-1:SQ_SHIFT]) * TERM_W'(count_inc);
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && out_free) begin
         logic over;
         over = 1'b0;
         for (int c = 0; c < NUM_CH; c++) begin
            if (spread_ff[c] > $signed({1'b0, thr_ff[c]})) over = 1'b1;
         end
         rsp_valid_ff <= 1'b1;
         rsp_index_ff <= count_ff;
         rsp_x_ff     <= hq_ff[0];
         rsp_y_ff     <= hq_ff[1];
         rsp_more_ff  <= (count_ff < CNT_W'(MAX_SAMPLES)) &&
                         ((count_ff < min_ff) || ((count_ff < max_ff) && over));
         for (int c = 0; c < NUM_CH; c++) rsp_mean_ff[c] <= mean_ff[c];
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.sample_index = rsp_index_ff;
   assign rsp_bus.offset_x     = rsp_x_ff;
   assign rsp_bus.offset_y     = rsp_y_ff;
   assign rsp_bus.more_samples = rsp_more_ff;
   assign rsp_bus.mean_red     = rsp_mean_ff[0];
   assign rsp_bus.mean_green   = rsp_mean_ff[1];
   assign rsp_bus.mean_blue    = rsp_mean_ff[2];

   // sample count never passes the hard limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SAMPLES))
      else $error("sample count beyond limit");

   // a start word clears the pixel
   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_bus.req_type |=> count_ff == '0 && mean_ff[0] == '0)
      else $error("start word did not clear pixel state");

   // no further samples requested once the limit is reached
   a_limit_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_index_ff == CNT_W'(MAX_SAMPLES) |-> !rsp_more_ff)
      else $error("more samples requested at limit");

   // an accepted word always starts the serial run
   a_fire_runs: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_RUN && step_ff == '0)
      else $error("accepted word did not start run");

endmodule

/* tb/tb_adaptive_pixel_sampler.sv */
`timescale 1ns / 1ps
module tb_adaptive_pixel_sampler;
   import apx_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_WAIT  = 60;
   localparam int LONG_HOLD   = 300;
   localparam int RANDOM_WORDS = 1400;

   typedef struct packed {
      logic [CNT_W-1:0]    sample_index;
      logic [HALTON_W-1:0] offset_x;
      logic [HALTON_W-1:0] offset_y;
      logic                more_samples;
      logic [COLOR_W-1:0]  mean_red;
      logic [COLOR_W-1:0]  mean_green;
      logic [COLOR_W-1:0]  mean_blue;
   } pixel_result_type;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [CSR_W-1:0]  csr_pwdata, csr_prdata;
   logic csr_pready;

   apx_req_if req_bus ();
   apx_rsp_if rsp_bus ();

   adaptive_pixel_sampler u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicts the sampler's results from its own copy of count, means and spreads
   class sampler_scoreboard;
      logic [THR_W-1:0]   thr [NUM_CH];
      logic [CNT_W-1:0]   min_cnt, max_cnt;
      int unsigned        count;
      logic [COLOR_W-1:0] mean [NUM_CH];
      int                 spread [NUM_CH];
      pixel_result_type   pending [$];
      int                 errors;
      int                 checked;
      int                 starts, samples, at_limit, more_seen;

      function new();
         errors = 0;
         checked = 0;
         starts = 0;
         samples = 0;
         at_limit = 0;
         more_seen = 0;
         clear_pixel();
         for (int c = 0; c < NUM_CH; c++) thr[c] = 31'd65536;
         min_cnt = 13'd4;
         max_cnt = 13'd64;
      endfunction

      function void clear_pixel();
         count = 0;
         for (int c = 0; c < NUM_CH; c++) begin
            mean[c] = '0;
            spread[c] = 0;
         end
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_W-1:0] value);
         case (idx)
            REG_THRESH_RED:   thr[0] = value[THR_W-1:0];
            REG_THRESH_GREEN: thr[1] = value[THR_W-1:0];
            REG_THRESH_BLUE:  thr[2] = value[THR_W-1:0];
            REG_MIN_SAMPLES:  min_cnt = value[CNT_W-1:0];
            REG_MAX_SAMPLES:  max_cnt = value[CNT_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [HALTON_W-1:0] halton(int unsigned n, int unsigned base);
         longint unsigned rev, denom;
         int unsigned m;
         rev = 0;
         denom = 1;
         m = n;
         while (m > 0) begin
            rev = rev * base + (m % base);
            m = m / base;
            denom = denom * base;
         end
         return HALTON_W'((rev << HALTON_W) / denom);
      endfunction

      // fold one accepted word into the pixel state and queue its result
      function void note_word(logic kind, logic [COLOR_W-1:0] col [NUM_CH]);
         longint d, dc, term, s, v;
         bit over;
         pixel_result_type r;
         over = 0;
         if (kind == 1'b0) begin
            clear_pixel();
            starts++;
         end else if (count < MAX_SAMPLES) begin
            samples++;
            for (int c = 0; c < NUM_CH; c++) begin
               d  = longint'(col[c]) - longint'(mean[c]);
               dc = d / longint'(count + 1);
               mean[c] = COLOR_W'(longint'(mean[c]) + dc);
               if (count > 0) begin
                  term = ((dc * dc) >>> SQ_SHIFT) * longint'(count + 1);
                  s = spread[c];
                  v = s + term - s / longint'(count);
                  if (v > 64'sd2147483647) v = 64'sd2147483647;
                  if (v < -64'sd2147483648) v = -64'sd2147483648;
                  spread[c] = int'(v);
               end
            end
            count++;
         end else begin
            at_limit++;
         end
         for (int c = 0; c < NUM_CH; c++)
            if (longint'(spread[c]) > longint'(thr[c])) over = 1;
         r.sample_index = CNT_W'(count);
         r.offset_x     = halton(count, BASE_X);
         r.offset_y     = halton(count, BASE_Y);
         r.more_samples = (count < min_cnt) || (count < max_cnt && over);
         if (count >= MAX_SAMPLES) r.more_samples = 1'b0;
         r.mean_red   = mean[0];
         r.mean_green = mean[1];
         r.mean_blue  = mean[2];
         if (r.more_samples) more_seen++;
         pending.push_back(r);
      endfunction

      function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
         end
      endfunction

      function void check_word(pixel_result_type act);
         pixel_result_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected result word: expected none actual %h", $time, act);
            return;
         end
         e = pending.pop_front();
         checked++;
         field("sample_index", e.sample_index, act.sample_index);
         field("offset_x", e.offset_x, act.offset_x);
         field("offset_y", e.offset_y, act.offset_y);
         field("more_samples", e.more_samples, act.more_samples);
         field("mean_red", e.mean_red, act.mean_red);
         field("mean_green", e.mean_green, act.mean_green);
         field("mean_blue", e.mean_blue, act.mean_blue);
      endfunction
   endclass

   sampler_scoreboard sb;
   bit quiet;
   bit hold_request;
   int idle_cycles;
   int words_sent;

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // monitors for accepted words, result words and the stall watchdog
   always @(posedge clock) begin
      logic [COLOR_W-1:0] col [NUM_CH];
      pixel_result_type act;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            col[0] = req_bus.color_red;
            col[1] = req_bus.color_green;
            col[2] = req_bus.color_blue;
            sb.note_word(req_bus.req_type, col);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            act.sample_index = rsp_bus.sample_index;
            act.offset_x     = rsp_bus.offset_x;
            act.offset_y     = rsp_bus.offset_y;
            act.more_samples = rsp_bus.more_samples;
            act.mean_red     = rsp_bus.mean_red;
            act.mean_green   = rsp_bus.mean_green;
            act.mean_blue    = rsp_bus.mean_blue;
            sb.check_word(act);
         end
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_adaptive_pixel_sampler: errors");
            $finish;
         end
      end
   end

   // result side backpressure: random bursts plus one long hold on request
   initial begin
      int hold;
      hold = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_bus.ready = 1'b0;
            hold--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready = 1'b0;
            hold = $urandom_range(1, 8) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // one input word, with an optional gap before it; returns at a falling edge
   task automatic send_word(logic kind, logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                            logic [COLOR_W-1:0] b);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.req_type    = kind;
      req_bus.color_red   = r;
      req_bus.color_green = g;
      req_bus.color_blue  = b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic drain();
      req_bus.valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   // apb write: setup then access cycle
   task automatic write_reg(csr_index_type idx, logic [CSR_W-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = ADDR_W'({idx, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic configure(logic [CSR_W-1:0] tr, logic [CSR_W-1:0] tg,
                            logic [CSR_W-1:0] tb, logic [CSR_W-1:0] lo,
                            logic [CSR_W-1:0] hi);
      drain();
      write_reg(REG_THRESH_RED, tr);
      write_reg(REG_THRESH_GREEN, tg);
      write_reg(REG_THRESH_BLUE, tb);
      write_reg(REG_MIN_SAMPLES, lo);
      write_reg(REG_MAX_SAMPLES, hi);
   endtask

   // a pixel: a start word then samples in one of a few color styles
   task automatic run_pixel(int len, int style);
      logic [COLOR_W-1:0] base [NUM_CH];
      logic [COLOR_W-1:0] col [NUM_CH];
      for (int c = 0; c < NUM_CH; c++) base[c] = COLOR_W'($urandom);
      send_word(1'b0, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
      for (int i = 0; i < len; i++) begin
         for (int c = 0; c < NUM_CH; c++) begin
            case (style)
               0: col[c] = COLOR_W'($urandom);
               1: col[c] = base[c] + COLOR_W'($urandom_range(0, 63)) - 16'd32;
               2: col[c] = (i % 2) ? 16'hFFFF : 16'h0000;
               default: col[c] = base[c];
            endcase
         end
         // occasional stray start in the middle of a pixel
         if ($urandom_range(0, 99) == 0)
            send_word(1'b0, col[0], col[1], col[2]);
         else
            send_word(1'b1, col[0], col[1], col[2]);
      end
   endtask

   initial begin
      int style, len, phase;
      sb = new();
      quiet = 0;
      hold_request = 0;
      idle_cycles = 0;
      words_sent = 0;
      req_bus.valid = 1'b0;
      req_bus.req_type = 1'b0;
      req_bus.color_red = '0;
      req_bus.color_green = '0;
      req_bus.color_blue = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed words under reset defaults
      send_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_word(1'b1, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b1, 16'hFFFF, 16'h0000, 16'h8000);
      send_word(1'b1, 16'h0001, 16'hFFFE, 16'h7FFF);
      send_word(1'b1, 16'h5555, 16'hAAAA, 16'h1234);
      send_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b0, 16'h0000, 16'h0000, 16'h0000);
      send_word(1'b1, 16'h1000, 16'h1000, 16'h1000);
      send_word(1'b1, 16'h1000, 16'h1000, 16'h1000);

      // minimum above maximum, zero thresholds
      configure(32'h0, 32'h0, 32'h0, 32'd10, 32'd3);
      run_pixel(12, 2);

      // long hold on the result side while words keep coming
      hold_request = 1;
      run_pixel(8, 0);

      // random pixels under several register settings
      phase = 0;
      while (words_sent < RANDOM_WORDS) begin
         if (phase % 6 == 0) begin
            case ((phase / 6) % 5)
               0: configure(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd1, 32'd1);
               1: configure(32'hFFFFFFFF, 32'h00010000, 32'h0, 32'd4, 32'd64);
               2: configure($urandom, $urandom, $urandom,
                            $urandom_range(1, 40), $urandom_range(1, 80));
               3: configure($urandom_range(0, 200000), $urandom_range(0, 200000),
                            $urandom_range(0, 200000), 32'd4096, 32'd4096);
               default: configure(32'h00001000, 32'h00100000, 32'h01000000,
                                  $urandom_range(1, 8), $urandom_range(8, 48));
            endcase
         end
         style = $urandom_range(0, 3);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 90) : $urandom_range(0, 20);
         if (words_sent > RANDOM_WORDS - 150) quiet = 1;
         run_pixel(len, style);
         phase++;
      end

      drain();
      $display("covered %0d starts, %0d samples, %0d words at the sample ceiling",
               sb.starts, sb.samples, sb.at_limit);
      $display("checked %0d results, %0d asked for more samples", sb.checked, sb.more_seen);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb_adaptive_pixel_sampler: clean");
      else
         $display("tb_adaptive_pixel_sampler: errors");
      $finish;
   end

endmodule
